// ===== rtl/core/axis_homing_sequencer_unit_assert.svh =====
// assertion macros for the homing sequencer
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef AXIS_HOMING_SEQUENCER_UNIT_ASSERT_SVH
`define AXIS_HOMING_SEQUENCER_UNIT_ASSERT_SVH

// checked on every rising edge outside reset
`define AHS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define AHS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ahs_pkg.sv =====
// shared types, codes and widths of the axis homing sequencer
// no dependencies
`default_nettype none

package ahs_pkg;

	// tick counter width and the width used for compares against the waits
	localparam int CountWidth = 16;
	localparam int WaitWidth  = 16;
	localparam int CmpWidth   = (CountWidth > WaitWidth) ? CountWidth : WaitWidth;
	localparam int LevelWidth = 16;
	localparam int CfgIndexWidth = 3;

	// input opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// approach kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_FIRST  = 2'd1;
	localparam logic [1:0] KIND_SECOND = 2'd2;

	// register indexes
	localparam logic [CfgIndexWidth-1:0] REG_STOP_LEVEL = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_UP_LEVEL   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_DOWN_LEVEL = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_FIRST_WAIT = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_TURN_WAIT  = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_FINAL_WAIT = 3'd5;

	// register reset values
	localparam logic signed [LevelWidth-1:0] STOP_LEVEL_RST = 16'sd7000;
	localparam logic signed [LevelWidth-1:0] UP_LEVEL_RST   = 16'sd14000;
	localparam logic signed [LevelWidth-1:0] DOWN_LEVEL_RST = -16'sd6500;
	localparam logic [WaitWidth-1:0] FIRST_WAIT_RST = 16'd1000;
	localparam logic [WaitWidth-1:0] TURN_WAIT_RST  = 16'd1500;
	localparam logic [WaitWidth-1:0] FINAL_WAIT_RST = 16'd2500;

	typedef struct packed {
		logic signed [LevelWidth-1:0] stop_level;
		logic signed [LevelWidth-1:0] up_level;
		logic signed [LevelWidth-1:0] down_level;
		logic [WaitWidth-1:0]         first_wait;
		logic [WaitWidth-1:0]         turn_wait;
		logic [WaitWidth-1:0]         final_wait;
	} cfg_t;

	typedef struct packed {
		logic                         cmd_active;
		logic                         home_reached;
		logic                         approach_chosen;
		logic [1:0]                   approach_kind;
		logic                         first_done;
		logic                         second_done;
		logic [CountWidth-1:0]        tick_count;
		logic signed [LevelWidth-1:0] drive_level;
		logic                         pause_armed;
	} state_t;

	// state after reset: everything clear but the pause latch
	localparam state_t STATE_RST = '{1'b0, 1'b0, 1'b0, KIND_NONE, 1'b0, 1'b0, '0, '0, 1'b1};

endpackage

`default_nettype wire

// ===== rtl/core/ahs_cfg_regs.sv =====
// configuration register file of the homing sequencer
// depends on ahs_pkg
`default_nettype none

module ahs_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ahs_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [ahs_pkg::LevelWidth-1:0]    cfg_data,
	output ahs_pkg::cfg_t                          cfg
);

	ahs_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_level <= ahs_pkg::STOP_LEVEL_RST;
			cfg_q.up_level   <= ahs_pkg::UP_LEVEL_RST;
			cfg_q.down_level <= ahs_pkg::DOWN_LEVEL_RST;
			cfg_q.first_wait <= ahs_pkg::FIRST_WAIT_RST;
			cfg_q.turn_wait  <= ahs_pkg::TURN_WAIT_RST;
			cfg_q.final_wait <= ahs_pkg::FINAL_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ahs_pkg::REG_STOP_LEVEL: cfg_q.stop_level <= cfg_data;
				ahs_pkg::REG_UP_LEVEL:   cfg_q.up_level   <= cfg_data;
				ahs_pkg::REG_DOWN_LEVEL: cfg_q.down_level <= cfg_data;
				ahs_pkg::REG_FIRST_WAIT: cfg_q.first_wait <= cfg_data;
				ahs_pkg::REG_TURN_WAIT:  cfg_q.turn_wait  <= cfg_data;
				ahs_pkg::REG_FINAL_WAIT: cfg_q.final_wait <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/ahs_step.sv =====
// next-state logic of the homing sequencer for one input beat
// depends on ahs_pkg
`default_nettype none

module ahs_step (
	input  wire logic          [1:0] opcode,
	input  wire logic                prox,
	input  wire ahs_pkg::cfg_t       cfg,
	input  wire ahs_pkg::state_t     cur,
	output ahs_pkg::state_t          nxt
);

	localparam int CmpW = ahs_pkg::CmpWidth;

	always_comb begin
		ahs_pkg::state_t n;
		logic [ahs_pkg::CountWidth-1:0] tc;
		logic [CmpW-1:0] t;
		logic [CmpW-1:0] fw;
		logic [CmpW-1:0] tw;
		logic [CmpW-1:0] finw;
		logic do_count;
		logic do_finish;

		n = cur;
		tc = cur.tick_count;
		t = CmpW'(cur.tick_count);
		fw = CmpW'(cfg.first_wait);
		tw = CmpW'(cfg.turn_wait);
		finw = CmpW'(cfg.final_wait);
		do_count = 1'b0;
		do_finish = 1'b0;

		if (opcode == ahs_pkg::OP_START) begin
			n.cmd_active = 1'b1;
		end else if (opcode == ahs_pkg::OP_CLEAR) begin
			n.cmd_active = 1'b0;
			n.home_reached = 1'b0;
			n.approach_chosen = 1'b0;
			n.approach_kind = ahs_pkg::KIND_NONE;
			n.first_done = 1'b0;
			n.second_done = 1'b0;
			n.tick_count = '0;
			n.drive_level = '0;
		end else if (opcode == ahs_pkg::OP_TICK && cur.cmd_active) begin
			// pick the approach on the first tick, unless home is already reached
			if (!cur.approach_chosen) begin
				if (!cur.home_reached) begin
					n.approach_kind = prox ? ahs_pkg::KIND_FIRST : ahs_pkg::KIND_SECOND;
				end
				if (n.approach_kind != ahs_pkg::KIND_NONE) begin
					n.approach_chosen = 1'b1;
				end
			end
			if (n.approach_chosen && n.approach_kind == ahs_pkg::KIND_FIRST) begin
				// approach with the switch detecting at the start
				do_count = 1'b1;
				if (!prox && cur.first_done && cur.second_done) begin
					do_finish = 1'b1;
				end else if (prox && cur.first_done && !cur.second_done && t >= tw) begin
					n.drive_level = cfg.up_level;
					n.second_done = 1'b1;
				end else if (prox && !cur.first_done && t < fw) begin
					n.drive_level = cfg.up_level;
					n.first_done = 1'b1;
				end else if (!prox && t >= fw && t < tw) begin
					n.drive_level = cfg.stop_level;
				end else if (!prox && t >= tw) begin
					n.drive_level = cfg.down_level;
				end
			end else if (n.approach_chosen && n.approach_kind == ahs_pkg::KIND_SECOND) begin
				// approach with the switch clear at the start
				do_count = 1'b1;
				if (!prox && cur.first_done && cur.second_done) begin
					do_finish = 1'b1;
				end else if (prox && cur.first_done && !cur.second_done) begin
					if (cur.pause_armed) begin
						n.drive_level = cfg.stop_level;
						tc = '0;
						n.pause_armed = 1'b0;
					end
					if (CmpW'(tc) >= fw) begin
						n.drive_level = cfg.up_level;
						n.second_done = 1'b1;
						n.pause_armed = 1'b1;
					end
				end else if (prox && !cur.first_done && !cur.second_done) begin
					if (t == '0) begin
						n.drive_level = cfg.stop_level;
					end
					if (t >= fw) begin
						n.drive_level = cfg.up_level;
					end
				end else if (!prox && !cur.first_done && !cur.second_done && t >= fw) begin
					n.first_done = 1'b1;
				end else if (!prox && cur.first_done && !cur.second_done && t >= tw
						&& t < finw) begin
					n.drive_level = cfg.stop_level;
				end else if (!prox && cur.first_done && !cur.second_done && t >= finw) begin
					n.drive_level = cfg.down_level;
				end else if (!prox && !cur.first_done && !cur.second_done && t == '0) begin
					n.drive_level = cfg.down_level;
					do_count = 1'b0;
				end
			end

			// completion or saturating count
			if (do_finish) begin
				n.drive_level = cfg.stop_level;
				n.tick_count = '0;
				n.approach_chosen = 1'b0;
				n.approach_kind = ahs_pkg::KIND_NONE;
				n.cmd_active = 1'b0;
				n.first_done = 1'b0;
				n.second_done = 1'b0;
				n.home_reached = 1'b1;
			end else if (do_count) begin
				n.tick_count = (tc == '1) ? tc : tc + 1'b1;
			end
		end

		nxt = n;
	end

endmodule

`default_nettype wire

// ===== rtl/core/axis_homing_sequencer_unit.sv =====
// top level of the axis homing sequencer: input stage, state and result register
// depends on ahs_pkg, ahs_cfg_regs, ahs_step and axis_homing_sequencer_unit_assert.svh
`default_nettype none

// Homing sequencer for one motor axis with a proximity switch. Each input beat
// is a tick, a start or a clear command and yields exactly one result beat with
// the drive level, the home flag and the busy flag after that beat. One beat is
// taken every clock cycle while s_tready is high: an accepted beat sits in the
// input stage, where its sequencer state update and result are computed
// combinationally, and the result register loads them when the beat moves on,
// so the result is offered from the result register. The input stage is ready
// when it is empty or when its beat moves on in the same cycle, which needs the
// result register to be empty or its result taken by m_tready; a stalled
// receiver therefore holds at most two beats inside the block.
// Configuration writes are meant for idle periods only.

`include "axis_homing_sequencer_unit_assert.svh"

module axis_homing_sequencer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [ahs_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [ahs_pkg::LevelWidth-1:0]    cfg_data,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // opcode[1:0], prox[2], rest ignored
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [23:0]                            m_tdata   // drive[15:0], at_home[16],
	                                                         // busy_res[17], zero
);

	ahs_pkg::cfg_t   cfg;
	ahs_pkg::state_t state_q;
	ahs_pkg::state_t state_nxt;

	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic       prox_s1;
	logic       valid_s2;
	logic signed [ahs_pkg::LevelWidth-1:0] drive_s2;
	logic       at_home_s2;
	logic       busy_s2;
	logic       advance;

	ahs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ahs_step u_step (
		.opcode (opcode_s1),
		.prox   (prox_s1),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt)
	);

	// handshake between stages
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1 <= s_tdata[1:0];
			prox_s1   <= s_tdata[2];
		end
	end

	// sequencer state, updated once per beat leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahs_pkg::STATE_RST;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2   <= state_nxt.drive_level;
			at_home_s2 <= state_nxt.home_reached;
			busy_s2    <= state_nxt.cmd_active;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, busy_s2, at_home_s2, drive_s2};

	// checks
	`AHS_ASSERT(a_state_holds, !advance |=> $stable(state_q), "state changed without a beat")
	`AHS_ASSERT(a_s1_holds, valid_s1 && !advance |=> valid_s1 && $stable(opcode_s1) && $stable(prox_s1), "input stage lost a stalled beat")
	`AHS_ASSERT(a_kind_chosen, state_q.approach_chosen == (state_q.approach_kind != ahs_pkg::KIND_NONE), "approach flag and kind disagree")
	`AHS_ASSERT_ALWAYS(a_pass_order, state_q.second_done |-> state_q.first_done, "second pass flagged before first")

endmodule

`default_nettype wire
